FILE: rtl/attractor_period_classifier_unit_macros.svh
// Assertion macros for the attractor period classifier checker
`ifndef ATTRACTOR_PERIOD_CLASSIFIER_UNIT_MACROS_SVH
`define ATTRACTOR_PERIOD_CLASSIFIER_UNIT_MACROS_SVH
// implication check on clk, disabled in reset
`define APC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check
`define APC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/apc_pkg.sv
// Package: types and constants of the attractor period classifier
`timescale 1ns / 1ps
package apc_pkg;
  localparam int LANES_DEF = 8;
  localparam int WINDOW_DEF = 16;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int VAL_W = 16;
  localparam int TOL_W = 15;
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [2:0] REG_TOL = 3'd0;
  localparam logic [2:0] REG_MAXP = 3'd1;
  localparam logic [2:0] REG_MAXS = 3'd2;
  localparam logic [2:0] REG_PRE = 3'd3;
  localparam logic [2:0] REG_ACTN = 3'd4;
  typedef enum logic [2:0] {
    ST_IDLE, ST_HRD, ST_HCMP, ST_TRD, ST_TCMP, ST_OUT
  } state_t;
endpackage

FILE: rtl/attractor_period_classifier_unit.sv
// Top level: attractor period classifier with history and attractor memories
`timescale 1ns / 1ps
// Idle samples, prerun samples and control requests are taken straight from idle; an examined
// sample scans the history (read, then compare per lag, stopping early on a match), and a detected
// cycle then scans the attractor memory (read, then compare per entry and phase) before the finish
// step. One request in flight; a new request waits until the result is taken.
// rst clears control state, counters and table count; memories are not cleared.
module attractor_period_classifier_unit #(
  parameter int LANES = apc_pkg::LANES_DEF,
  parameter int TABLE_DEPTH = apc_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic signed [15:0] value_0, value_1, value_2, value_3,
  input  logic signed [15:0] value_4, value_5, value_6, value_7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  attractor_label,
  output logic        new_attractor,
  output logic [3:0]  cycle_length,
  output logic [9:0]  steps_used,
  output logic        table_full
);
  import apc_pkg::*;
  localparam int WINDOW = WINDOW_DEF;
  localparam int VW = LANES * VAL_W;
  localparam int WA = $clog2(WINDOW);
  localparam int TA = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [14:0] tol;
  logic [4:0]  maxp;
  logic [9:0]  maxs, pre;
  logic [3:0]  actn, nl;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0; maxp <= 5'd16; maxs <= 10'd250; pre <= 10'd100; actn <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOL:  tol <= cfg_data;
        REG_MAXP: maxp <= cfg_data[4:0];
        REG_MAXS: maxs <= cfg_data[9:0];
        REG_PRE:  pre <= cfg_data[9:0];
        REG_ACTN: actn <= cfg_data[3:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    if (actn == 4'd0) nl = 4'd1;
    else if ({28'd0, actn} > LANES) nl = 4'(LANES);
    else nl = actn;
  end

  logic [VAL_W*8-1:0] vin8;
  assign vin8 = {value_7, value_6, value_5, value_4, value_3, value_2, value_1, value_0};

  logic [VW-1:0] hmem [WINDOW];
  logic [VW-1:0] tmem [TABLE_DEPTH];
  logic [VW-1:0] hq, tq, cur;
  logic [WA-1:0] hra;
  logic [TA-1:0] tra;
  logic          hwe, twe;
  logic [WA-1:0] hwa;
  logic [VW-1:0] hwd;
  logic [CW-1:0] cnt;
  always_ff @(posedge clk) begin
    if (hwe) hmem[hwa] <= hwd;
    hq <= hmem[hra];
  end
  always_ff @(posedge clk) begin
    if (twe) tmem[TA'(cnt)] <= cur;
    tq <= tmem[tra];
  end

  state_t state, state_next;
  logic        done;
  logic [9:0]  prec, j;
  logic [3:0]  back, limit, period;
  logic [CW-1:0] t;
  logic [3:0]  c;
  logic [6:0]  r_label;
  logic        r_new, r_full;
  logic [3:0]  r_len;
  logic [9:0]  r_steps;
  logic        hsame, tsame;
  logic        acc;

  apc_match #(.LANES(LANES)) u_hm (.a(hq), .b(cur), .tol(tol), .nlanes(nl), .same(hsame));
  apc_match #(.LANES(LANES)) u_tm (.a(tq), .b(hq), .tol(tol), .nlanes(nl), .same(tsame));

  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign acc = in_valid && in_ready;
  logic examine;
  assign examine = acc && action == ACT_SAMPLE && !done && prec >= pre;

  logic [4:0] mp;
  logic [3:0] lim0;
  always_comb begin
    mp = (maxp > 5'(WINDOW)) ? 5'(WINDOW) : maxp;
    lim0 = (mp >= 5'd1) ? 4'(mp - 5'd1) : 4'd0;
    if ({6'd0, lim0} > j) lim0 = j[3:0];
  end
  logic [9:0] ms;
  assign ms = (maxs == 10'd0) ? 10'd1 : maxs;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (examine) state_next = (lim0 == 4'd0) ? ST_OUT : ST_HRD;
      ST_HRD:  state_next = ST_HCMP;
      ST_HCMP: begin
        if (hsame) state_next = (cnt == '0) ? ST_OUT : ST_TRD;
        else if (back >= limit) state_next = ST_OUT;
        else state_next = ST_HRD;
      end
      ST_TRD:  state_next = ST_TCMP;
      ST_TCMP: begin
        if (tsame) state_next = ST_OUT;
        else if (c + 4'd1 >= period && t + 1'b1 >= cnt) state_next = ST_OUT;
        else state_next = ST_TRD;
      end
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    hwe = examine;
    hwa = WA'(j);
    hwd = vin8[VW-1:0];
    hra = (state == ST_TRD) ? WA'(j - 10'(c)) : WA'(j - 10'(back));
    tra = TA'(t);
    twe = (state == ST_OUT) && fin_found && !fin_known && (cnt < CW'(TABLE_DEPTH));
  end

  // ST_OUT is the finish step; it decides the result of an examined sample
  logic fin_found, fin_known;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; done <= 1'b1; prec <= '0; j <= '0; cnt <= '0;
      out_valid <= 1'b0; fin_found <= 1'b0; fin_known <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (acc && action == ACT_START) begin
        prec <= '0; j <= '0; done <= 1'b0;
      end
      if (acc && action == ACT_CLEAR) cnt <= '0;
      if (acc && action == ACT_SAMPLE && !done && prec < pre) prec <= prec + 10'd1;
      case (state)
        ST_IDLE: if (examine) begin
          cur <= vin8[VW-1:0]; back <= 4'd1; limit <= lim0;
          fin_found <= 1'b0; fin_known <= 1'b0; t <= '0; c <= '0;
        end
        ST_HCMP: begin
          if (hsame) begin fin_found <= 1'b1; period <= back; end
          else back <= back + 4'd1;
        end
        ST_TCMP: begin
          if (tsame) begin fin_known <= 1'b1; r_label <= 7'(t) + 7'd1; end
          else if (c + 4'd1 >= period) begin c <= '0; t <= t + 1'b1; end
          else c <= c + 4'd1;
        end
        ST_OUT: begin
          if (!fin_found) begin
            if (j + 10'd1 < ms) j <= j + 10'd1;
            else begin
              done <= 1'b1; out_valid <= 1'b1; r_label <= '0; r_new <= 1'b0;
              r_len <= '0; r_full <= 1'b0; r_steps <= j;
            end
          end else begin
            done <= 1'b1; out_valid <= 1'b1; r_len <= period; r_steps <= j;
            if (fin_known) begin r_new <= 1'b0; r_full <= 1'b0; end
            else if (cnt < CW'(TABLE_DEPTH)) begin
              cnt <= cnt + 1'b1; r_label <= 7'(cnt) + 7'd1; r_new <= 1'b1;
              r_full <= 1'b0;
            end else begin
              r_label <= '0; r_new <= 1'b0; r_full <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
  // TRD also reads the history memory at j-c; TCMP compares tq against hq
  assign attractor_label = r_label;
  assign new_attractor = r_new;
  assign cycle_length = r_len;
  assign steps_used = r_steps;
  assign table_full = r_full;
endmodule

FILE: rtl/apc_match.sv
// Tolerance compare of two state vectors over the active lanes
`timescale 1ns / 1ps
module apc_match #(
  parameter int LANES = apc_pkg::LANES_DEF
) (
  input  logic [LANES*apc_pkg::VAL_W-1:0] a,
  input  logic [LANES*apc_pkg::VAL_W-1:0] b,
  input  logic [apc_pkg::TOL_W-1:0]       tol,
  input  logic [3:0]                      nlanes,
  output logic                            same
);
  import apc_pkg::*;
  always_comb begin
    logic signed [VAL_W:0] d;
    logic [VAL_W:0] m;
    same = 1'b1;
    for (int k = 0; k < LANES; k++) begin
      d = $signed({a[k*VAL_W+VAL_W-1], a[k*VAL_W +: VAL_W]})
        - $signed({b[k*VAL_W+VAL_W-1], b[k*VAL_W +: VAL_W]});
      m = d[VAL_W] ? -d : d;
      if (4'(k) < nlanes && m > {2'b0, tol}) same = 1'b0;
    end
  end
endmodule

FILE: rtl/apc_checker.sv
// Port-level checker for the attractor period classifier, with bind
`timescale 1ns / 1ps
`include "attractor_period_classifier_unit_macros.svh"
module apc_checker (
  input logic clk, rst, in_valid, in_ready, out_valid, out_ready,
  input logic [6:0] attractor_label,
  input logic new_attractor, table_full,
  input logic [3:0] cycle_length
);
  `APC_ASSERT_IMP(a_new_label, out_valid && new_attractor, attractor_label != 7'd0)
  `APC_ASSERT_IMP(a_full_nolabel, out_valid && table_full, attractor_label == 7'd0 && !new_attractor)
  `APC_ASSERT_IMP(a_label_len, out_valid && attractor_label != 7'd0, cycle_length != 4'd0)
  `APC_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid)
endmodule
bind attractor_period_classifier_unit apc_checker u_apc_checker (.*);

FILE: tb/tb_top.sv
// Testbench for the attractor period classifier: directed and random state streams, scoreboard
`timescale 1ns / 1ps
module tb_top;
  import apc_pkg::*;

  typedef struct packed {
    logic [1:0] act;
    logic signed [7:0][15:0] v;
  } req_t;

  typedef struct packed {
    logic [6:0] label;
    logic fresh;
    logic [3:0] period;
    logic [9:0] steps;
    logic full;
  } res_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [1:0] action = '0;
  logic signed [15:0] vin [8];
  logic out_valid, out_ready = 0;
  logic [6:0] attractor_label;
  logic new_attractor, table_full;
  logic [3:0] cycle_length;
  logic [9:0] steps_used;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  attractor_period_classifier_unit u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .action,
    .value_0(vin[0]), .value_1(vin[1]), .value_2(vin[2]), .value_3(vin[3]),
    .value_4(vin[4]), .value_5(vin[5]), .value_6(vin[6]), .value_7(vin[7]),
    .out_valid, .out_ready, .attractor_label, .new_attractor, .cycle_length,
    .steps_used, .table_full
  );

  // predictor state
  logic [14:0] tol_r;
  logic [4:0] maxp_r;
  logic [9:0] maxs_r, pre_r;
  logic [3:0] actn_r;
  logic signed [15:0] hist [16][8];
  logic signed [15:0] atab [64][8];
  int atab_n, pre_cnt, step_cnt;
  bit idle_srch;

  req_t pend_q[$];
  res_t exp_q[$];
  int mismatches = 0, results_seen = 0, searches = 0;
  bit stall_free = 0, hold_send = 0;
  bit in_took = 0;
  int quiet = 0;

  function automatic bit states_match(logic signed [15:0] a [8], logic signed [15:0] b [8]);
    int n;
    int d;
    n = actn_r < 1 ? 1 : (actn_r > 8 ? 8 : actn_r);
    for (int k = 0; k < n; k++) begin
      d = a[k] - b[k];
      if (d < 0) d = -d;
      if (d > tol_r) return 0;
    end
    return 1;
  endfunction

  task automatic classify_req(req_t r);
    int j, slot, mp, lim, period;
    bit found, known;
    res_t o;
    logic signed [15:0] cur [8];
    if (r.act == ACT_START) begin
      pre_cnt = 0; step_cnt = 0; idle_srch = 0;
      return;
    end
    if (r.act == ACT_CLEAR) begin
      atab_n = 0;
      return;
    end
    if (r.act != ACT_SAMPLE || idle_srch) return;
    if (pre_cnt < pre_r) begin
      pre_cnt++;
      return;
    end
    j = step_cnt; slot = j % 16;
    for (int k = 0; k < 8; k++) hist[slot][k] = r.v[k];
    cur = hist[slot];
    mp = maxp_r > 16 ? 16 : maxp_r;
    lim = mp >= 1 ? mp - 1 : 0;
    if (lim > j) lim = j;
    found = 0; period = 0;
    for (int b = 1; b <= lim && !found; b++)
      if (states_match(hist[(j - b) % 16], cur)) begin
        found = 1; period = b;
      end
    o = '0;
    if (!found) begin
      if (j + 1 < (maxs_r < 1 ? 1 : maxs_r)) begin
        step_cnt = (j + 1) & 10'h3ff;
        return;
      end
    end else begin
      known = 0;
      for (int t = 0; t < atab_n && !known; t++)
        for (int c = 0; c < period && !known; c++)
          if (states_match(atab[t], hist[(j - c) % 16])) begin
            known = 1; o.label = 7'(t + 1);
          end
      if (!known) begin
        if (atab_n < 64) begin
          atab[atab_n] = cur;
          atab_n++;
          o.label = 7'(atab_n); o.fresh = 1'b1;
        end else o.full = 1'b1;
      end
    end
    idle_srch = 1;
    o.period = 4'(period);
    o.steps = 10'(j);
    exp_q.push_back(o);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (pend_q.size() > 0 && !(hold_send && exp_q.size() > 0) &&
            (stall_free || $urandom_range(99) >= 18)) begin
          in_valid <= 1;
          action <= pend_q[0].act;
          for (int k = 0; k < 8; k++) vin[k] <= pend_q[0].v[k];
        end else in_valid <= 0;
      end
      out_ready <= stall_free || $urandom_range(99) >= 18;
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got, want;
    if (!rst) begin
      quiet <= (in_valid && in_ready) || (out_valid && out_ready) ? 0 : quiet + 1;
      in_took = in_valid && in_ready;
      if (in_took) classify_req(pend_q.pop_front());
      if (out_valid && out_ready) begin
        got = {attractor_label, new_attractor, cycle_length, steps_used, table_full};
        results_seen <= results_seen + 1;
        if (exp_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", got);
        end else begin
          want = exp_q.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch exp %p got %p", want, got);
          end
        end
      end
      if (quiet > 200000) begin
        $display("timeout, %0d pending", pend_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic req_t mk(logic [1:0] a, logic signed [15:0] base, int jit);
    req_t r;
    r.act = a;
    for (int k = 0; k < 8; k++)
      r.v[k] = 16'(base + $signed(16'($urandom_range(2 * jit))) - jit);
    return r;
  endfunction

  function automatic req_t rnd_req(logic [1:0] a);
    req_t r;
    r.act = a;
    for (int k = 0; k < 8; k++) r.v[k] = 16'($urandom);
    return r;
  endfunction

  task automatic wr_reg(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= 15'(val);
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_TOL: tol_r = 15'(val);
      REG_MAXP: maxp_r = 5'(val);
      REG_MAXS: maxs_r = 10'(val);
      REG_PRE: pre_r = 10'(val);
      REG_ACTN: actn_r = 4'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || in_valid || exp_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // one search: start, prerun noise, then a loop of period p with jitter, or noise when p is 0
  task automatic push_search(int p, int len, int jit, logic signed [15:0] seed);
    logic signed [15:0] pts [16];
    searches++;
    pend_q.push_back(mk(ACT_START, 0, 0));
    for (int i = 0; i < pre_r; i++) pend_q.push_back(rnd_req(ACT_SAMPLE));
    for (int i = 0; i < 16; i++) pts[i] = seed + 16'(i * 1500);
    for (int i = 0; i < len; i++)
      pend_q.push_back(p == 0 ? rnd_req(ACT_SAMPLE) : mk(ACT_SAMPLE, pts[i % p], jit));
  endtask

  initial begin
    int p, n;
    for (int k = 0; k < 8; k++) vin[k] = '0;
    tol_r = 0; maxp_r = 16; maxs_r = 250; pre_r = 100; actn_r = 8;
    atab_n = 0; pre_cnt = 0; step_cnt = 0; idle_srch = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed
    wr_reg(REG_TOL, 0); wr_reg(REG_MAXP, 16); wr_reg(REG_MAXS, 1023);
    wr_reg(REG_PRE, 2); wr_reg(REG_ACTN, 8);
    pend_q.push_back(mk(ACT_SAMPLE, 16'sh7fff, 0));
    pend_q.push_back(mk(2'd3, -16'sh8000, 0));
    pend_q.push_back(mk(ACT_START, 0, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 16'sh7fff, 0));
    pend_q.push_back(mk(ACT_SAMPLE, -16'sh8000, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 16'sh7fff, 0));
    pend_q.push_back(mk(ACT_SAMPLE, -16'sh8000, 0));
    pend_q.push_back(mk(ACT_CLEAR, 0, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 16'sh7fff, 0));
    pend_q.push_back(mk(ACT_SAMPLE, -16'sh8000, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 16'sh7fff, 0));
    pend_q.push_back(mk(ACT_START, 0, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 0, 0));
    pend_q.push_back(mk(ACT_START, 0, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 5, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 5, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 5, 0));
    pend_q.push_back(mk(ACT_SAMPLE, 5, 0));
    drain();
    // settings sweep: extremes then random
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin wr_reg(REG_TOL, 32767); wr_reg(REG_MAXP, 2); wr_reg(REG_MAXS, 1);
          wr_reg(REG_PRE, 0); wr_reg(REG_ACTN, 1); end
        1: begin wr_reg(REG_TOL, 0); wr_reg(REG_MAXP, 0); wr_reg(REG_MAXS, 0);
          wr_reg(REG_ACTN, 0); end
        2: begin wr_reg(REG_MAXP, 31); wr_reg(REG_ACTN, 15); wr_reg(REG_MAXS, 40); end
        3: begin wr_reg(REG_PRE, 20); wr_reg(REG_MAXS, 1023); wr_reg(REG_MAXP, 1); end
        default: begin
          wr_reg(REG_TOL, $urandom_range(3) == 0 ? $urandom_range(32767) : $urandom_range(64));
          wr_reg(REG_MAXP, $urandom_range(2, 16)); wr_reg(REG_MAXS, $urandom_range(1, 60));
          wr_reg(REG_PRE, $urandom_range(0, 5)); wr_reg(REG_ACTN, $urandom_range(1, 8));
        end
      endcase
      stall_free = (ph == 6);
      hold_send = (ph == 5);
      n = (ph == 3) ? 1 : 5;
      for (int s = 0; s < n; s++) begin
        p = $urandom_range(0, 15);
        if ($urandom_range(9) == 0) pend_q.push_back(mk(ACT_CLEAR, 0, 0));
        if ($urandom_range(9) == 0) pend_q.push_back(rnd_req(2'($urandom_range(3))));
        push_search(p, ph == 3 ? 1030 : $urandom_range(1, 25), $urandom_range(0, 40),
          16'($urandom_range(5) == 0 ? $urandom : $urandom_range(8) * 4000));
      end
      drain();
    end
    hold_send = 0;
    // fill the table past its capacity
    wr_reg(REG_TOL, 0); wr_reg(REG_MAXP, 3); wr_reg(REG_MAXS, 5);
    wr_reg(REG_PRE, 0); wr_reg(REG_ACTN, 8);
    for (int s = 0; s < 70; s++) push_search(1, 2, 0, 16'(s * 900 - 30000));
    drain();
    $display("checked %0d results from %0d searches over several register settings",
      results_seen, searches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
